// ----- rtl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, register and row codes, and the rounding and
// saturation functions used by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    // fixed-point format
    localparam int FRAC_BITS  = 16;
    localparam int W          = 32;
    localparam int WIDE_W     = 2 * W;

    // normalizer widths
    localparam int MAG_W      = 64;
    localparam int POS_W      = $clog2(MAG_W);
    localparam int M_W        = 30;
    localparam int SQ_W       = 2 * M_W + 2;
    localparam int RES_W      = SQ_W + 1;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int LEN_W      = ROOT_STEPS;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int NUM_W      = M_W + FRAC_BITS + 1;
    localparam int SIDE_W     = 6 * W;

    // stage counts
    localparam int NORM_LAT   = 6 + ROOT_STEPS + 1 + Q_W + 1;
    localparam int BASIS_LAT  = 6;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;

    // matrix row codes
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;
    localparam logic [1:0] ROW_HOM   = 2'd3;

    typedef logic signed [W-1:0]      fix_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam logic [W-1:0] UNIT_ONE = W'(1) << FRAC_BITS;
    localparam wide_t FIX_MAX = (wide_t'(1) <<< (W - 1)) - wide_t'(1);
    localparam wide_t FIX_MIN = -(wide_t'(1) <<< (W - 1));

    // pipeline control between modules
    typedef struct packed {
        logic adv;
        logic valid;
    } lav_ctl_t;

    // finished matrix of one item
    typedef struct packed {
        logic [2:0][W-1:0] r;
        logic [2:0][W-1:0] u;
        logic [2:0][W-1:0] f;
        logic [2:0][W-1:0] t;
    } lav_mat_t;

    // round by FRAC_BITS, half away from zero
    function automatic wide_t round_frac(input wide_t v);
        logic [WIDE_W-1:0] m;
        m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        m = (m + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[WIDE_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // clamp to the signed W-bit range
    function automatic logic [W-1:0] sat_fix(input wide_t v);
        logic [W-1:0] s;
        if (v > FIX_MAX) begin
            s = FIX_MAX[W-1:0];
        end else if (v < FIX_MIN) begin
            s = FIX_MIN[W-1:0];
        end else begin
            s = v[W-1:0];
        end
        return s;
    endfunction

endpackage

// ----- rtl/lav_ifs.sv -----
// ----------------------------------------------------------------------------
// lav_ifs: stream channels of the look-at view matrix block
// Point channel (eye and target) and matrix row channel, valid/ready.
// ----------------------------------------------------------------------------
interface lav_point_if import lav_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [W-1:0] eye_x;
    logic [W-1:0] eye_y;
    logic [W-1:0] eye_z;
    logic [W-1:0] target_x;
    logic [W-1:0] target_y;
    logic [W-1:0] target_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    output ready);
endinterface

interface lav_row_if import lav_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [1:0]   row_index;
    logic [W-1:0] col0;
    logic [W-1:0] col1;
    logic [W-1:0] col2;
    logic [W-1:0] col3;
    logic         last_row;

    modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                    input ready);
    modport sink   (input valid, row_index, col0, col1, col2, col3, last_row,
                    output ready);
endinterface

// ----- rtl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm: pipelined vector normalizer
// Block-scales three components, takes an integer square root one result
// bit per stage, then divides each component one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lav_ctl_t               ctl,
    input  logic [2:0][MAG_W-1:0]  vec,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   vout,
    output logic [2:0][W-1:0]      unit,
    output logic [SIDE_W-1:0]      side_out
);

    typedef struct packed {
        logic              zero;
        logic [2:0]        neg;
        logic [SIDE_W-1:0] side;
    } ctx_t;

    localparam logic [POS_W-1:0] NORM_POS = POS_W'(M_W - 1);

    function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    logic [NORM_LAT-1:0]      vld_reg;

    logic [2:0][MAG_W-1:0]    mag1_next;
    logic [2:0][MAG_W-1:0]    mag1_reg;
    ctx_t                     c1_reg;
    logic [MAG_W-1:0]         mx2_next;
    logic [MAG_W-1:0]         mx2_reg;
    logic [2:0][MAG_W-1:0]    mag2_reg;
    ctx_t                     c2_reg;
    logic [POS_W-1:0]         pos3_reg;
    logic [2:0][MAG_W-1:0]    mag3_reg;
    ctx_t                     c3_reg;
    logic [2:0][M_W-1:0]      m4_next;
    logic [2:0][M_W-1:0]      m4_reg;
    ctx_t                     c4_reg;
    logic [2:0][2*M_W-1:0]    sq5_reg;
    logic [2:0][M_W-1:0]      m5_reg;
    ctx_t                     c5_reg;

    logic [SQ_W-1:0]          rx_reg [0:ROOT_STEPS];
    logic [RES_W-1:0]         rr_reg [0:ROOT_STEPS];
    logic [2:0][M_W-1:0]      rm_reg [0:ROOT_STEPS];
    ctx_t                     rc_reg [0:ROOT_STEPS];

    logic [LEN_W-1:0]         root_len;
    logic [2:0][NUM_W-1:0]    dr_reg [0:Q_W];
    logic [LEN_W-1:0]         dl_reg [0:Q_W];
    logic [2:0][Q_W-1:0]      dq_reg [0:Q_W];
    ctx_t                     dc_reg [0:Q_W];

    logic [2:0][W-1:0]        unit_reg;
    logic [SIDE_W-1:0]        side_reg;

    // valid bits ride a shift line beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[NORM_LAT-2:0], ctl.valid};
        end
    end

    // take magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            mag1_next[i] = vec[i][MAG_W-1] ? (~vec[i] + MAG_W'(1)) : vec[i];
        end
    end

    // find the largest magnitude
    always_comb
    begin
        mx2_next = mag1_reg[0];
        if (mag1_reg[1] > mx2_next) begin
            mx2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx2_next) begin
            mx2_next = mag1_reg[2];
        end
    end

    // scale so the largest lands in [2^29, 2^30)
    always_comb
    begin
        logic [MAG_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (pos3_reg >= NORM_POS) begin
                sh = mag3_reg[i] >> (pos3_reg - NORM_POS);
            end else begin
                sh = mag3_reg[i] << (NORM_POS - pos3_reg);
            end
            m4_next[i] = sh[M_W-1:0];
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (ctl.adv) begin
            mag1_reg     <= mag1_next;
            c1_reg.zero  <= 1'b0;
            c1_reg.neg   <= {vec[2][MAG_W-1], vec[1][MAG_W-1], vec[0][MAG_W-1]};
            c1_reg.side  <= side_in;

            mx2_reg      <= mx2_next;
            mag2_reg     <= mag1_reg;
            c2_reg       <= c1_reg;

            pos3_reg     <= msb_pos(mx2_reg);
            mag3_reg     <= mag2_reg;
            c3_reg       <= '{zero: (mx2_reg == '0), neg: c2_reg.neg, side: c2_reg.side};

            m4_reg       <= m4_next;
            c4_reg       <= c3_reg;

            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= (2*M_W)'(m4_reg[i]) * (2*M_W)'(m4_reg[i]);
            end
            m5_reg       <= m4_reg;
            c5_reg       <= c4_reg;

            rx_reg[0]    <= SQ_W'(sq5_reg[0]) + SQ_W'(sq5_reg[1]) + SQ_W'(sq5_reg[2]);
            rr_reg[0]    <= '0;
            rm_reg[0]    <= m5_reg;
            rc_reg[0]    <= c5_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam int B = SQ_W - 2 - 2 * k;
        logic [RES_W-1:0] bitv;
        logic [RES_W-1:0] trial;
        logic [SQ_W-1:0]  x_next;
        logic [RES_W-1:0] r_next;

        assign bitv  = RES_W'(1) << B;
        assign trial = rr_reg[k] + bitv;

        always_comb
        begin
            if ({1'b0, rx_reg[k]} >= trial) begin
                x_next = rx_reg[k] - trial[SQ_W-1:0];
                r_next = (rr_reg[k] >> 1) + bitv;
            end else begin
                x_next = rx_reg[k];
                r_next = rr_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv) begin
                rx_reg[k+1] <= x_next;
                rr_reg[k+1] <= r_next;
                rm_reg[k+1] <= rm_reg[k];
                rc_reg[k+1] <= rc_reg[k];
            end
        end
    end

    assign root_len = rr_reg[ROOT_STEPS][LEN_W-1:0];

    // form rounded numerators
    always_ff @(posedge clk)
    begin
        if (ctl.adv) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= (NUM_W'(rm_reg[ROOT_STEPS][i]) << FRAC_BITS)
                              + NUM_W'(root_len >> 1);
            end
            dl_reg[0] <= root_len;
            dq_reg[0] <= '0;
            dc_reg[0] <= rc_reg[ROOT_STEPS];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = Q_W - 1 - j;
        logic [NUM_W-1:0]        dvs;
        logic [2:0][NUM_W-1:0]   rem_next;
        logic [2:0][Q_W-1:0]     q_next;

        assign dvs = NUM_W'(dl_reg[j]) << B;

        always_comb
        begin
            for (int i = 0; i < 3; i++) begin
                if (dr_reg[j][i] >= dvs) begin
                    rem_next[i] = dr_reg[j][i] - dvs;
                    q_next[i]   = dq_reg[j][i] | (Q_W'(1) << B);
                end else begin
                    rem_next[i] = dr_reg[j][i];
                    q_next[i]   = dq_reg[j][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv) begin
                dr_reg[j+1] <= rem_next;
                dq_reg[j+1] <= q_next;
                dl_reg[j+1] <= dl_reg[j];
                dc_reg[j+1] <= dc_reg[j];
            end
        end
    end

    // restore signs; a zero vector stays zero
    always_ff @(posedge clk)
    begin
        if (ctl.adv) begin
            for (int i = 0; i < 3; i++) begin
                if (dc_reg[Q_W].zero) begin
                    unit_reg[i] <= '0;
                end else if (dc_reg[Q_W].neg[i]) begin
                    unit_reg[i] <= -W'(dq_reg[Q_W][i]);
                end else begin
                    unit_reg[i] <= W'(dq_reg[Q_W][i]);
                end
            end
            side_reg <= dc_reg[Q_W].side;
        end
    end

    assign vout     = vld_reg[NORM_LAT-1];
    assign unit     = unit_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/lav_basis.sv -----
// ----------------------------------------------------------------------------
// lav_basis: true-up vector and translation terms
// From unit forward and right and the eye point, forms up = f x r and the
// three rounded, saturated dot products with the eye.
// ----------------------------------------------------------------------------
module lav_basis import lav_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  lav_ctl_t           ctl,
    input  logic [2:0][W-1:0]  f_in,
    input  logic [2:0][W-1:0]  r_in,
    input  logic [2:0][W-1:0]  e_in,
    output logic               vout,
    output lav_mat_t           mat
);

    logic [BASIS_LAT-1:0]      vld_reg;

    logic [5:0][WIDE_W-1:0]    pfr_reg;
    logic [2:0][WIDE_W-1:0]    pre_reg;
    logic [2:0][WIDE_W-1:0]    pfe_reg;
    logic [2:0][W-1:0]         r1_reg, f1_reg, e1_reg;

    logic [2:0][WIDE_W-1:0]    ud2_reg;
    logic [WIDE_W-1:0]         sr2_reg, sf2_reg;
    logic [2:0][W-1:0]         r2_reg, f2_reg, e2_reg;

    logic [2:0][W-1:0]         u3_reg, r3_reg, f3_reg, e3_reg;
    logic [W-1:0]              t0_3_reg, t2_3_reg;

    logic [2:0][WIDE_W-1:0]    pue4_reg;
    logic [2:0][W-1:0]         u4_reg, r4_reg, f4_reg;
    logic [W-1:0]              t0_4_reg, t2_4_reg;

    logic [WIDE_W-1:0]         su5_reg;
    logic [2:0][W-1:0]         u5_reg, r5_reg, f5_reg;
    logic [W-1:0]              t0_5_reg, t2_5_reg;

    lav_mat_t                  mat_reg;

    // valid bits ride a shift line beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[BASIS_LAT-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv) begin
            // cross and dot products
            pfr_reg[0] <= WIDE_W'($signed(f_in[1])) * WIDE_W'($signed(r_in[2]));
            pfr_reg[1] <= WIDE_W'($signed(f_in[2])) * WIDE_W'($signed(r_in[1]));
            pfr_reg[2] <= WIDE_W'($signed(f_in[2])) * WIDE_W'($signed(r_in[0]));
            pfr_reg[3] <= WIDE_W'($signed(f_in[0])) * WIDE_W'($signed(r_in[2]));
            pfr_reg[4] <= WIDE_W'($signed(f_in[0])) * WIDE_W'($signed(r_in[1]));
            pfr_reg[5] <= WIDE_W'($signed(f_in[1])) * WIDE_W'($signed(r_in[0]));
            for (int i = 0; i < 3; i++) begin
                pre_reg[i] <= WIDE_W'($signed(r_in[i])) * WIDE_W'($signed(e_in[i]));
                pfe_reg[i] <= WIDE_W'($signed(f_in[i])) * WIDE_W'($signed(e_in[i]));
            end
            r1_reg <= r_in;
            f1_reg <= f_in;
            e1_reg <= e_in;

            // differences and sums
            ud2_reg[0] <= $signed(pfr_reg[0]) - $signed(pfr_reg[1]);
            ud2_reg[1] <= $signed(pfr_reg[2]) - $signed(pfr_reg[3]);
            ud2_reg[2] <= $signed(pfr_reg[4]) - $signed(pfr_reg[5]);
            sr2_reg <= $signed(pre_reg[0]) + $signed(pre_reg[1]) + $signed(pre_reg[2]);
            sf2_reg <= $signed(pfe_reg[0]) + $signed(pfe_reg[1]) + $signed(pfe_reg[2]);
            r2_reg <= r1_reg;
            f2_reg <= f1_reg;
            e2_reg <= e1_reg;

            // round and clamp up, first and third translation
            for (int i = 0; i < 3; i++) begin
                u3_reg[i] <= sat_fix(round_frac($signed(ud2_reg[i])));
            end
            t0_3_reg <= sat_fix(-round_frac($signed(sr2_reg)));
            t2_3_reg <= sat_fix(round_frac($signed(sf2_reg)));
            r3_reg <= r2_reg;
            f3_reg <= f2_reg;
            e3_reg <= e2_reg;

            // up dot eye products
            for (int i = 0; i < 3; i++) begin
                pue4_reg[i] <= WIDE_W'($signed(u3_reg[i])) * WIDE_W'($signed(e3_reg[i]));
            end
            u4_reg   <= u3_reg;
            r4_reg   <= r3_reg;
            f4_reg   <= f3_reg;
            t0_4_reg <= t0_3_reg;
            t2_4_reg <= t2_3_reg;

            su5_reg  <= $signed(pue4_reg[0]) + $signed(pue4_reg[1]) + $signed(pue4_reg[2]);
            u5_reg   <= u4_reg;
            r5_reg   <= r4_reg;
            f5_reg   <= f4_reg;
            t0_5_reg <= t0_4_reg;
            t2_5_reg <= t2_4_reg;

            // second translation, assemble
            mat_reg.r    <= r5_reg;
            mat_reg.u    <= u5_reg;
            mat_reg.f    <= f5_reg;
            mat_reg.t[0] <= t0_5_reg;
            mat_reg.t[1] <= sat_fix(-round_frac($signed(su5_reg)));
            mat_reg.t[2] <= t2_5_reg;
        end
    end

    assign vout = vld_reg[BASIS_LAT-1];
    assign mat  = mat_reg;

endmodule

// ----- rtl/look_at_view_matrix_core.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: look-at view matrix generator, signed Q16.16
// Takes eye and target points, emits the four rows of the view matrix.
// ----------------------------------------------------------------------------
// Usage:
//   points: one beat carries eye and target; accepted when valid and ready.
//   rows:   four beats per point beat, row_index 0..3, last_row on row 3.
//           Rows hold right, up, negated forward (each with its translation
//           in col3) and 0,0,0,1.0.
//   cfg:    cfg_we writes cfg_index (0 up_x, 1 up_y, 2 up_z) with cfg_data;
//           other indexes are dropped. Write only while the block is empty.
// Depth: a point beat passes two normalizers of 56 stages each (31
//   square-root stages, 17 divide stages) plus the cross-product and
//   translation stages on its way to row 0 on the output.
// Pacing: set by the four output rows; while a matrix waits at the tail,
//   a new point is taken in the cycle the row 3 beat leaves.
// Reset: clears all valid bits and the output row state; up resets to
//   (0, 1.0, 0). A receiver stall with a full tail freezes the pipeline.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core import lav_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [W-1:0]          cfg_data,
    lav_point_if.sink             points,
    lav_row_if.source             rows
);

    logic [W-1:0]            up_x_reg, up_y_reg, up_z_reg;

    logic                    adv;
    logic                    ser_free;
    logic                    tail_valid;

    logic                    in_valid_reg;
    logic [2:0][W-1:0]       eye_reg;
    logic [2:0][W:0]         diff_reg;

    lav_ctl_t                fn_ctl;
    logic [2:0][MAG_W-1:0]   fn_vec;
    logic                    fn_vout;
    logic [2:0][W-1:0]       fn_unit;
    logic [SIDE_W-1:0]       fn_side;

    logic                    c1_valid_reg, c2_valid_reg;
    logic [5:0][WIDE_W-1:0]  pc_reg;
    logic [2:0][W-1:0]       f1_reg, e1_reg;
    logic [2:0][WIDE_W-1:0]  rraw_reg;
    logic [2:0][W-1:0]       f2_reg, e2_reg;

    lav_ctl_t                rn_ctl;
    logic                    rn_vout;
    logic [2:0][W-1:0]       rn_unit;
    logic [SIDE_W-1:0]       rn_side;

    lav_ctl_t                bs_ctl;
    lav_mat_t                bs_mat;

    logic                    ser_valid_reg;
    logic [1:0]              ser_row_reg;
    lav_mat_t                ser_mat_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            up_x_reg <= '0;
            up_y_reg <= UNIT_ONE;
            up_z_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_UP_X: up_x_reg <= cfg_data;
                CFG_UP_Y: up_y_reg <= cfg_data;
                CFG_UP_Z: up_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless the tail is blocked
    assign ser_free      = !ser_valid_reg || (rows.ready && ser_row_reg == ROW_HOM);
    assign adv           = !tail_valid || ser_free;
    assign points.ready  = adv && rst_n;

    // input stage: capture eye, form target minus eye
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= points.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            eye_reg[0]  <= points.eye_x;
            eye_reg[1]  <= points.eye_y;
            eye_reg[2]  <= points.eye_z;
            diff_reg[0] <= (W+1)'($signed(points.target_x)) - (W+1)'($signed(points.eye_x));
            diff_reg[1] <= (W+1)'($signed(points.target_y)) - (W+1)'($signed(points.eye_y));
            diff_reg[2] <= (W+1)'($signed(points.target_z)) - (W+1)'($signed(points.eye_z));
        end
    end

    // forward normalizer
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            fn_vec[i] = MAG_W'($signed(diff_reg[i]));
        end
    end

    assign fn_ctl.adv   = adv;
    assign fn_ctl.valid = in_valid_reg;

    lav_norm u_fwd_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fn_ctl),
        .vec      (fn_vec),
        .side_in  ({{(SIDE_W - 3*W){1'b0}}, eye_reg}),
        .vout     (fn_vout),
        .unit     (fn_unit),
        .side_out (fn_side)
    );

    // right = up x forward, products then differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end else if (adv) begin
            c1_valid_reg <= fn_vout;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            pc_reg[0] <= WIDE_W'($signed(up_y_reg)) * WIDE_W'($signed(fn_unit[2]));
            pc_reg[1] <= WIDE_W'($signed(up_z_reg)) * WIDE_W'($signed(fn_unit[1]));
            pc_reg[2] <= WIDE_W'($signed(up_z_reg)) * WIDE_W'($signed(fn_unit[0]));
            pc_reg[3] <= WIDE_W'($signed(up_x_reg)) * WIDE_W'($signed(fn_unit[2]));
            pc_reg[4] <= WIDE_W'($signed(up_x_reg)) * WIDE_W'($signed(fn_unit[1]));
            pc_reg[5] <= WIDE_W'($signed(up_y_reg)) * WIDE_W'($signed(fn_unit[0]));
            f1_reg    <= fn_unit;
            e1_reg    <= fn_side[3*W-1:0];

            rraw_reg[0] <= $signed(pc_reg[0]) - $signed(pc_reg[1]);
            rraw_reg[1] <= $signed(pc_reg[2]) - $signed(pc_reg[3]);
            rraw_reg[2] <= $signed(pc_reg[4]) - $signed(pc_reg[5]);
            f2_reg      <= f1_reg;
            e2_reg      <= e1_reg;
        end
    end

    // right normalizer
    assign rn_ctl.adv   = adv;
    assign rn_ctl.valid = c2_valid_reg;

    lav_norm u_right_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rn_ctl),
        .vec      (rraw_reg),
        .side_in  ({f2_reg, e2_reg}),
        .vout     (rn_vout),
        .unit     (rn_unit),
        .side_out (rn_side)
    );

    // true up and translation terms
    assign bs_ctl.adv   = adv;
    assign bs_ctl.valid = rn_vout;

    lav_basis u_basis (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bs_ctl),
        .f_in  (rn_side[SIDE_W-1:3*W]),
        .r_in  (rn_unit),
        .e_in  (rn_side[3*W-1:0]),
        .vout  (tail_valid),
        .mat   (bs_mat)
    );

    // row sequencer: hold one matrix, send four beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ser_valid_reg <= 1'b0;
            ser_row_reg   <= ROW_RIGHT;
        end else if (adv && tail_valid) begin
            ser_valid_reg <= 1'b1;
            ser_row_reg   <= ROW_RIGHT;
        end else if (ser_valid_reg && rows.ready) begin
            if (ser_row_reg == ROW_HOM) begin
                ser_valid_reg <= 1'b0;
            end else begin
                ser_row_reg <= ser_row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tail_valid) begin
            ser_mat_reg <= bs_mat;
        end
    end

    // select the row on the output
    assign rows.valid     = ser_valid_reg;
    assign rows.row_index = ser_row_reg;
    assign rows.last_row  = (ser_row_reg == ROW_HOM);

    always_comb
    begin
        case (ser_row_reg)
            ROW_RIGHT: begin
                rows.col0 = ser_mat_reg.r[0];
                rows.col1 = ser_mat_reg.r[1];
                rows.col2 = ser_mat_reg.r[2];
                rows.col3 = ser_mat_reg.t[0];
            end
            ROW_UP: begin
                rows.col0 = ser_mat_reg.u[0];
                rows.col1 = ser_mat_reg.u[1];
                rows.col2 = ser_mat_reg.u[2];
                rows.col3 = ser_mat_reg.t[1];
            end
            ROW_FWD: begin
                rows.col0 = -ser_mat_reg.f[0];
                rows.col1 = -ser_mat_reg.f[1];
                rows.col2 = -ser_mat_reg.f[2];
                rows.col3 = ser_mat_reg.t[2];
            end
            default: begin
                rows.col0 = '0;
                rows.col1 = '0;
                rows.col2 = '0;
                rows.col3 = UNIT_ONE;
            end
        endcase
    end

    // after the last row the next beat opens a new matrix
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.ready && rows.last_row
        |=> !rows.valid || rows.row_index == ROW_RIGHT)
        else $error("row sequence did not restart after the last row");

    // rows of one matrix advance one at a time
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.ready && !rows.last_row
        |=> rows.valid && rows.row_index == 2'($past(rows.row_index) + 2'd1))
        else $error("row index skipped or matrix cut short");

    // the homogeneous row is constant
    a_row_hom: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.row_index == ROW_HOM
        |-> rows.col0 == '0 && rows.col1 == '0 && rows.col2 == '0
            && rows.col3 == UNIT_ONE)
        else $error("bottom row is not 0,0,0,1");

    // no new point is taken while a matrix mid-row is blocked with a full tail
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid && ser_valid_reg && ser_row_reg != ROW_HOM |-> !points.ready)
        else $error("input accepted while pipeline tail is blocked");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for look_at_view_matrix_core
// Drives eye/target points with random gaps, stalls the row channel at
// random, predicts all four matrix rows per point and compares every beat.
// ----------------------------------------------------------------------------
module tb;
    import lav_pkg::*;

    localparam int LIMIT = 400000;
    localparam int N_RAND = 150;

    typedef struct {
        logic [1:0]   row_index;
        logic [W-1:0] c0;
        logic [W-1:0] c1;
        logic [W-1:0] c2;
        logic [W-1:0] c3;
        logic         last_row;
    } view_row_t;

    typedef struct {
        logic [W-1:0] ex;
        logic [W-1:0] ey;
        logic [W-1:0] ez;
        logic [W-1:0] tx;
        logic [W-1:0] ty;
        logic [W-1:0] tz;
        bit           known;
        logic [W-1:0] r0_c3;
    } point_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [W-1:0] cfg_data;

    lav_point_if points ();
    lav_row_if rows ();

    look_at_view_matrix_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (points.sink),
        .rows      (rows.source)
    );

    longint up_vec [3];
    view_row_t row_queue [$];
    int fails;
    int cycles;
    bit long_hold;
    bit stim_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint mag_of(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint round_q(input longint v);
        longint unsigned m;
        m = mag_of(v);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // scale to unit length; zero stays zero
    task automatic unit_vec(inout longint v [3]);
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag_of(v[i]);
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
        begin
            return;
        end
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endtask

    function automatic view_row_t make_row(input logic [1:0] idx, input longint a,
                                           input longint b, input longint c,
                                           input longint d);
        view_row_t r;
        r.row_index = idx;
        r.c0 = W'(clamp32(a));
        r.c1 = W'(clamp32(b));
        r.c2 = W'(clamp32(c));
        r.c3 = W'(clamp32(d));
        r.last_row = (idx == ROW_HOM);
        return r;
    endfunction

    // predict the four rows of one point beat
    task automatic predict_view(input point_row_t p);
        longint e [3];
        longint f [3];
        longint r [3];
        longint u [3];
        longint t0;
        longint t1;
        longint t2;
        e[0] = longint'($signed(p.ex));
        e[1] = longint'($signed(p.ey));
        e[2] = longint'($signed(p.ez));
        f[0] = longint'($signed(p.tx)) - e[0];
        f[1] = longint'($signed(p.ty)) - e[1];
        f[2] = longint'($signed(p.tz)) - e[2];
        unit_vec(f);
        r[0] = up_vec[1] * f[2] - up_vec[2] * f[1];
        r[1] = up_vec[2] * f[0] - up_vec[0] * f[2];
        r[2] = up_vec[0] * f[1] - up_vec[1] * f[0];
        unit_vec(r);
        u[0] = clamp32(round_q(f[1] * r[2] - f[2] * r[1]));
        u[1] = clamp32(round_q(f[2] * r[0] - f[0] * r[2]));
        u[2] = clamp32(round_q(f[0] * r[1] - f[1] * r[0]));
        t0 = -round_q(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
        t1 = -round_q(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
        t2 = round_q(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]);
        row_queue.push_back(make_row(ROW_RIGHT, r[0], r[1], r[2], t0));
        row_queue.push_back(make_row(ROW_UP, u[0], u[1], u[2], t1));
        row_queue.push_back(make_row(ROW_FWD, -f[0], -f[1], -f[2], t2));
        row_queue.push_back(make_row(ROW_HOM, 0, 0, 0, longint'(UNIT_ONE)));
    endtask

    task automatic write_up(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_UP_X) up_vec[0] = longint'($signed(val));
        else if (idx == CFG_UP_Y) up_vec[1] = longint'($signed(val));
        else if (idx == CFG_UP_Z) up_vec[2] = longint'($signed(val));
    endtask

    // drop valid and wait for the pipeline to drain before a register write
    task automatic drain_rows();
        points.valid <= 1'b0;
        while (row_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    // offer one beat, hold until accepted; valid stays up for a following beat
    task automatic send_point(input point_row_t p);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            points.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        points.valid <= 1'b1;
        points.eye_x <= p.ex;
        points.eye_y <= p.ey;
        points.eye_z <= p.ez;
        points.target_x <= p.tx;
        points.target_y <= p.ty;
        points.target_z <= p.tz;
        @(posedge clk);
        while (!points.ready)
        begin
            @(posedge clk);
        end
        predict_view(p);
        @(negedge clk);
    endtask

    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return W'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            3: return W'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic point_row_t rand_point();
        point_row_t p;
        p.ex = rand_coord();
        p.ey = rand_coord();
        p.ez = rand_coord();
        p.tx = rand_coord();
        p.ty = rand_coord();
        p.tz = rand_coord();
        if ($urandom_range(0, 19) == 0)
        begin
            p.tx = p.ex;
            p.ty = p.ey;
            p.tz = p.ez;
        end
        p.known = 1'b0;
        p.r0_c3 = '0;
        return p;
    endfunction

    // directed stimulus; col3 of row 0 typed in where obvious
    point_row_t directed [] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0},
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_0000, 1'b1, 32'h0},
        '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b1, 32'h0},
        '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h7fff_ffff, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
          32'hffff_ffff, 1'b0, 32'h0},
        '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
          32'h1234_5678, 1'b1, 32'h0},
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1, 32'h0},
        '{32'hffff_ffff, 32'h1, 32'h0, 32'h1, 32'hffff_ffff, 32'h0, 1'b0, 32'h0},
        '{32'h7fff_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_0000, 1'b0, 32'h0},
        '{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
          32'hcccc_cccc, 1'b0, 32'h0}
    };

    // stimulus
    initial
    begin
        point_row_t p;
        cfg_we = 1'b0;
        cfg_index = CFG_UP_X;
        cfg_data = '0;
        points.valid = 1'b0;
        points.eye_x = '0;
        points.eye_y = '0;
        points.eye_z = '0;
        points.target_x = '0;
        points.target_y = '0;
        points.target_z = '0;
        up_vec[0] = 0;
        up_vec[1] = longint'(UNIT_ONE);
        up_vec[2] = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_point(directed[i]);
            if (directed[i].known)
            begin
                row_queue[row_queue.size() - 4].c3 = directed[i].r0_c3;
            end
        end
        // unknown register index is dropped
        drain_rows();
        write_up(2'd3, 32'hdead_beef);
        send_point(directed[3]);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_rows();
            case (ph)
                0:
                begin
                    write_up(CFG_UP_X, 32'h7fff_ffff);
                    write_up(CFG_UP_Y, 32'h8000_0000);
                    write_up(CFG_UP_Z, 32'h7fff_ffff);
                end
                1:
                begin
                    write_up(CFG_UP_X, 32'h0);
                    write_up(CFG_UP_Y, 32'h0);
                    write_up(CFG_UP_Z, 32'h0);
                end
                2:
                begin
                    write_up(CFG_UP_X, 32'h8000_0000);
                    write_up(CFG_UP_Y, 32'h0);
                    write_up(CFG_UP_Z, 32'h8000_0000);
                end
                5:
                begin
                    write_up(CFG_UP_X, 32'h0);
                    write_up(CFG_UP_Y, 32'h0001_0000);
                    write_up(CFG_UP_Z, 32'h0);
                end
                default:
                begin
                    write_up(CFG_UP_X, $urandom);
                    write_up(CFG_UP_Y, $urandom);
                    write_up(CFG_UP_Z, $urandom);
                end
            endcase
            if (ph == 3)
            begin
                long_hold = 1'b1;
            end
            for (int k = 0; k < N_RAND / 6; k++)
            begin
                p = rand_point();
                send_point(p);
                // pause until all rows are out once
                if (ph == 4 && k == 5)
                begin
                    points.valid <= 1'b0;
                    while (row_queue.size() != 0) @(negedge clk);
                end
            end
        end
        points.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // row receiver: random stalls plus one long hold
    initial
    begin
        int stall;
        rows.ready = 1'b0;
        long_hold = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rows.ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                rows.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rows.ready <= 1'b1;
            @(posedge clk);
            while (!rows.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // compare each row beat with the oldest prediction
    always @(posedge clk)
    begin
        view_row_t w;
        if (rst_n && rows.valid && rows.ready)
        begin
            if (row_queue.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected row beat row_index=%0d", $realtime, rows.row_index);
            end
            else
            begin
                w = row_queue.pop_front();
                if (rows.row_index !== w.row_index)
                begin
                    fails++;
                    $display("%0t: row_index expected %0d actual %0d", $realtime,
                             w.row_index, rows.row_index);
                end
                if (rows.col0 !== w.c0)
                begin
                    fails++;
                    $display("%0t: row %0d col0 expected %h actual %h", $realtime,
                             w.row_index, w.c0, rows.col0);
                end
                if (rows.col1 !== w.c1)
                begin
                    fails++;
                    $display("%0t: row %0d col1 expected %h actual %h", $realtime,
                             w.row_index, w.c1, rows.col1);
                end
                if (rows.col2 !== w.c2)
                begin
                    fails++;
                    $display("%0t: row %0d col2 expected %h actual %h", $realtime,
                             w.row_index, w.c2, rows.col2);
                end
                if (rows.col3 !== w.c3)
                begin
                    fails++;
                    $display("%0t: row %0d col3 expected %h actual %h", $realtime,
                             w.row_index, w.c3, rows.col3);
                end
                if (rows.last_row !== w.last_row)
                begin
                    fails++;
                    $display("%0t: row %0d last_row expected %b actual %b", $realtime,
                             w.row_index, w.last_row, rows.last_row);
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        fails = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (stim_done && row_queue.size() == 0)
            begin
                repeat (200) @(posedge clk);
                if (fails == 0)
                begin
                    $display("RESULT: OK");
                end
                else
                begin
                    $display("RESULT: ERROR");
                end
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
rtl/lav_pkg.sv
rtl/lav_ifs.sv
rtl/lav_norm.sv
rtl/lav_basis.sv
rtl/look_at_view_matrix_core.sv
bench/tb.sv
